// File: hw/rtl/coag_pkg.sv
`default_nettype none

package coag_pkg;

  localparam int unsigned NumDimsDefault = 2;

  localparam int unsigned AddrW    = 48;
  localparam int unsigned CfgAddrW = 5;
  localparam int unsigned CfgDataW = 32;

  // Register map, one word per register
  typedef enum logic [2:0] {
    REG_IMG_SIZE         = 3'd0,
    REG_KER_SIZE         = 3'd1,
    REG_OUT_SIZE         = 3'd2,
    REG_STRIDE_PAIR      = 3'd3,
    REG_DILATION_PAIR    = 3'd4,
    REG_PAD_PAIR         = 3'd5,
    REG_NUM_IN_CHANNELS  = 3'd6,
    REG_NUM_OUT_CHANNELS = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [27:0] img_size;
    logic [27:0] kernel_dims;
    logic [27:0] output_dims;
    logic [15:0] stride_pair;
    logic [15:0] dilation_pair;
    logic [15:0] pad_pair;
    logic [9:0]  num_in_channels;
    logic [9:0]  num_out_channels;
  } cfg_t;

  localparam logic [27:0] ImgSizeRst     = 28'h0010001;
  localparam logic [27:0] KerSizeRst     = 28'h0010001;
  localparam logic [27:0] OutSizeRst     = 28'h0010001;
  localparam logic [15:0] StridePairRst  = 16'h0101;
  localparam logic [15:0] DilationRst    = 16'h0101;
  localparam logic [15:0] PadPairRst     = 16'h0000;
  localparam logic [9:0]  NumInChRst     = 10'd1;
  localparam logic [9:0]  NumOutChRst    = 10'd1;

endpackage

`default_nettype wire

// File: hw/rtl/coag_regs.sv
`default_nettype none

module coag_regs (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [coag_pkg::CfgAddrW-1:0]      paddr,
  input  wire logic [coag_pkg::CfgDataW-1:0]      pwdata,
  output logic      [coag_pkg::CfgDataW-1:0]      prdata,
  output logic                                    pready,
  output coag_pkg::cfg_t                          cfg_o
);

  coag_pkg::cfg_t     cfg_q, cfg_d;
  coag_pkg::reg_idx_e idx;
  logic               wr_en;

  assign idx    = coag_pkg::reg_idx_e'(paddr[coag_pkg::CfgAddrW-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        coag_pkg::REG_IMG_SIZE:         cfg_d.img_size         = pwdata[27:0];
        coag_pkg::REG_KER_SIZE:         cfg_d.kernel_dims      = pwdata[27:0];
        coag_pkg::REG_OUT_SIZE:         cfg_d.output_dims      = pwdata[27:0];
        coag_pkg::REG_STRIDE_PAIR:      cfg_d.stride_pair      = pwdata[15:0];
        coag_pkg::REG_DILATION_PAIR:    cfg_d.dilation_pair    = pwdata[15:0];
        coag_pkg::REG_PAD_PAIR:         cfg_d.pad_pair         = pwdata[15:0];
        coag_pkg::REG_NUM_IN_CHANNELS:  cfg_d.num_in_channels  = pwdata[9:0];
        coag_pkg::REG_NUM_OUT_CHANNELS: cfg_d.num_out_channels = pwdata[9:0];
        default:                        cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      coag_pkg::REG_IMG_SIZE:         prdata = {4'd0, cfg_q.img_size};
      coag_pkg::REG_KER_SIZE:         prdata = {4'd0, cfg_q.kernel_dims};
      coag_pkg::REG_OUT_SIZE:         prdata = {4'd0, cfg_q.output_dims};
      coag_pkg::REG_STRIDE_PAIR:      prdata = {16'd0, cfg_q.stride_pair};
      coag_pkg::REG_DILATION_PAIR:    prdata = {16'd0, cfg_q.dilation_pair};
      coag_pkg::REG_PAD_PAIR:         prdata = {16'd0, cfg_q.pad_pair};
      coag_pkg::REG_NUM_IN_CHANNELS:  prdata = {22'd0, cfg_q.num_in_channels};
      coag_pkg::REG_NUM_OUT_CHANNELS: prdata = {22'd0, cfg_q.num_out_channels};
      default:                        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.img_size         <= coag_pkg::ImgSizeRst;
      cfg_q.kernel_dims      <= coag_pkg::KerSizeRst;
      cfg_q.output_dims      <= coag_pkg::OutSizeRst;
      cfg_q.stride_pair      <= coag_pkg::StridePairRst;
      cfg_q.dilation_pair    <= coag_pkg::DilationRst;
      cfg_q.pad_pair         <= coag_pkg::PadPairRst;
      cfg_q.num_in_channels  <= coag_pkg::NumInChRst;
      cfg_q.num_out_channels <= coag_pkg::NumOutChRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/coag_pipe.sv
`default_nettype none

module coag_pipe #(
  parameter int unsigned NumDims = coag_pkg::NumDimsDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire coag_pkg::cfg_t                cfg_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [7:0]                    batch_index_i,
  input  wire logic [9:0]                    in_channel_i,
  input  wire logic [9:0]                    out_channel_i,
  input  wire logic [11:0]                   out_row_i,
  input  wire logic [11:0]                   out_col_i,
  input  wire logic [11:0]                   ker_row_i,
  input  wire logic [11:0]                   ker_col_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [coag_pkg::AddrW-1:0]    output_addr_o,
  output logic      [coag_pkg::AddrW-1:0]    weight_addr_o,
  output logic      [coag_pkg::AddrW-1:0]    input_addr_o,
  output logic                               in_bounds_o
);

  localparam bit TwoD = (NumDims >= 2);

  typedef struct packed {
    logic [17:0] bn;     // batch * out channels
    logic [19:0] on;     // out channel * in channels
    logic [17:0] bi;     // batch * in channels
    logic [19:0] row_os;
    logic [19:0] row_kd;
    logic [19:0] col_os;
    logic [19:0] col_kd;
    logic [9:0]  och;
    logic [9:0]  ich;
    logic [11:0] orow;
    logic [11:0] ocol;
    logic [11:0] krow;
    logic [11:0] kcol;
  } s1_t;

  typedef struct packed {
    logic [29:0] oa;
    logic [31:0] wa;
    logic [29:0] ia;
    logic [11:0] irow;
    logic [11:0] icol;
    logic        ok;
    logic [11:0] orow;
    logic [11:0] ocol;
    logic [11:0] krow;
    logic [11:0] kcol;
  } s2_t;

  typedef struct packed {
    logic [41:0] oa;
    logic [43:0] wa;
    logic [41:0] ia;
    logic [11:0] icol;
    logic        ok;
    logic [11:0] ocol;
    logic [11:0] kcol;
  } s3_t;

  typedef struct packed {
    logic [coag_pkg::AddrW-1:0] oa;
    logic [coag_pkg::AddrW-1:0] wa;
    logic [coag_pkg::AddrW-1:0] ia;
    logic                       ok;
  } s4_t;

  s1_t s1_q, s1_d;
  s2_t s2_q, s2_d;
  s3_t s3_q, s3_d;
  s4_t s4_q, s4_d;
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  // Sizes; heights count as one in the one-dimensional build
  logic [11:0] oh, kh, ih, ow, kw, iw;
  assign oh = TwoD ? cfg_i.output_dims[27:16] : 12'd1;
  assign kh = TwoD ? cfg_i.kernel_dims[27:16] : 12'd1;
  assign ih = TwoD ? cfg_i.img_size[27:16] : 12'd1;
  assign ow = cfg_i.output_dims[11:0];
  assign kw = cfg_i.kernel_dims[11:0];
  assign iw = cfg_i.img_size[11:0];

  // A stage takes a new item when it is empty or its item moves on
  assign rdy4       = !v4_q | out_ready_i;
  assign rdy3       = !v3_q | rdy4;
  assign rdy2       = !v2_q | rdy3;
  assign rdy1       = !v1_q | rdy2;
  assign in_ready_o = rdy1;

  // Stage 1: first products
  logic [11:0] orow_in, krow_in;
  assign orow_in = TwoD ? out_row_i : 12'd0;
  assign krow_in = TwoD ? ker_row_i : 12'd0;

  always_comb begin
    s1_d.bn     = 18'(batch_index_i) * 18'(cfg_i.num_out_channels);
    s1_d.on     = 20'(out_channel_i) * 20'(cfg_i.num_in_channels);
    s1_d.bi     = 18'(batch_index_i) * 18'(cfg_i.num_in_channels);
    s1_d.row_os = 20'(orow_in) * 20'(cfg_i.stride_pair[15:8]);
    s1_d.row_kd = 20'(krow_in) * 20'(cfg_i.dilation_pair[15:8]);
    s1_d.col_os = 20'(out_col_i) * 20'(cfg_i.stride_pair[7:0]);
    s1_d.col_kd = 20'(ker_col_i) * 20'(cfg_i.dilation_pair[7:0]);
    s1_d.och    = out_channel_i;
    s1_d.ich    = in_channel_i;
    s1_d.orow   = orow_in;
    s1_d.ocol   = out_col_i;
    s1_d.krow   = krow_in;
    s1_d.kcol   = ker_col_i;
  end

  // Stage 2: channel terms times heights, input coordinates and bounds
  logic [17:0] a1, i1;
  logic [19:0] w1;
  logic [20:0] sum_r, sum_c, diff_r, diff_c, pad_r, pad_c;
  logic        ok_r, ok_c;

  always_comb begin
    a1     = s1_q.bn + 18'(s1_q.och);
    w1     = s1_q.on + 20'(s1_q.ich);
    i1     = s1_q.bi + 18'(s1_q.ich);
    pad_r  = 21'(cfg_i.pad_pair[15:8]);
    pad_c  = 21'(cfg_i.pad_pair[7:0]);
    sum_r  = 21'(s1_q.row_os) + 21'(s1_q.row_kd);
    sum_c  = 21'(s1_q.col_os) + 21'(s1_q.col_kd);
    diff_r = sum_r - pad_r;
    diff_c = sum_c - pad_c;
    ok_r   = TwoD ? ((sum_r >= pad_r) && (diff_r < 21'(ih))) : 1'b1;
    ok_c   = (sum_c >= pad_c) && (diff_c < 21'(iw));

    s2_d.oa   = 30'(a1) * 30'(oh);
    s2_d.wa   = 32'(w1) * 32'(kh);
    s2_d.ia   = 30'(i1) * 30'(ih);
    s2_d.irow = TwoD ? diff_r[11:0] : 12'd0;
    s2_d.icol = diff_c[11:0];
    s2_d.ok   = ok_r & ok_c;
    s2_d.orow = s1_q.orow;
    s2_d.ocol = s1_q.ocol;
    s2_d.krow = s1_q.krow;
    s2_d.kcol = s1_q.kcol;
  end

  // Stage 3: add rows, multiply by widths
  logic [29:0] oa_row, ia_row;
  logic [31:0] wa_row;

  always_comb begin
    oa_row    = s2_q.oa + 30'(s2_q.orow);
    wa_row    = s2_q.wa + 32'(s2_q.krow);
    ia_row    = s2_q.ia + 30'(s2_q.irow);
    s3_d.oa   = 42'(oa_row) * 42'(ow);
    s3_d.wa   = 44'(wa_row) * 44'(kw);
    s3_d.ia   = 42'(ia_row) * 42'(iw);
    s3_d.icol = s2_q.icol;
    s3_d.ok   = s2_q.ok;
    s3_d.ocol = s2_q.ocol;
    s3_d.kcol = s2_q.kcol;
  end

  // Stage 4: add columns; padding points give input address zero
  always_comb begin
    s4_d.oa = coag_pkg::AddrW'(s3_q.oa) + coag_pkg::AddrW'(s3_q.ocol);
    s4_d.wa = coag_pkg::AddrW'(s3_q.wa) + coag_pkg::AddrW'(s3_q.kcol);
    s4_d.ia = s3_q.ok ? (coag_pkg::AddrW'(s3_q.ia) + coag_pkg::AddrW'(s3_q.icol))
                      : '0;
    s4_d.ok = s3_q.ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) s1_q <= s1_d;
    if (rdy2 && v1_q)       s2_q <= s2_d;
    if (rdy3 && v2_q)       s3_q <= s3_d;
    if (rdy4 && v3_q)       s4_q <= s4_d;
  end

  assign out_valid_o   = v4_q;
  assign output_addr_o = s4_q.oa;
  assign weight_addr_o = s4_q.wa;
  assign input_addr_o  = s4_q.ia;
  assign in_bounds_o   = s4_q.ok;

  // Any empty stage opens the input
  a_ready_when_not_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(v1_q && v2_q && v3_q && v4_q) |-> in_ready_o)
    else $error("input stalled with a bubble in the pipeline");

  a_accept_fills_s1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v1_q)
    else $error("accepted item did not reach the first stage");

  a_pad_addr_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !in_bounds_o |-> (input_addr_o == '0))
    else $error("padding point with nonzero input address");

  a_full_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && v2_q && v3_q && v4_q && !out_ready_i |=> v1_q && v2_q && v3_q && v4_q)
    else $error("item lost while the pipeline was stalled");

endmodule

`default_nettype wire

// File: hw/rtl/conv_operand_address_generator_unit.sv
`default_nettype none

// Channel  Direction  Handshake                 Payload
// cfg      in         psel/penable/pwrite       paddr, pwdata -> prdata (pready tied high)
// in       in         in_valid_i/in_ready_o     batch, channels, output and kernel coordinates
// out      out        out_valid_o/out_ready_i   output, weight, input address, in_bounds
//
// One item per cycle sustained while out_ready_i stays high; an accepted item passes the
// registers s1_q, s2_q, s3_q and s4_q in turn, and out_valid_o shows v4_q.
// The four stages are: first products, channel terms times heights with bounds,
// rows added and times widths, columns added.
// Reset clears the valid bits and loads register defaults; payload is not reset.
// A stalled output holds stages full behind it; any empty stage keeps in_ready_o high.
module conv_operand_address_generator_unit #(
  parameter int unsigned NumDims = coag_pkg::NumDimsDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [coag_pkg::CfgAddrW-1:0] paddr,
  input  wire logic [coag_pkg::CfgDataW-1:0] pwdata,
  output logic      [coag_pkg::CfgDataW-1:0] prdata,
  output logic                               pready,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [7:0]                    batch_index_i,
  input  wire logic [9:0]                    in_channel_i,
  input  wire logic [9:0]                    out_channel_i,
  input  wire logic [11:0]                   out_row_i,
  input  wire logic [11:0]                   out_col_i,
  input  wire logic [11:0]                   ker_row_i,
  input  wire logic [11:0]                   ker_col_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [coag_pkg::AddrW-1:0]    output_addr_o,
  output logic      [coag_pkg::AddrW-1:0]    weight_addr_o,
  output logic      [coag_pkg::AddrW-1:0]    input_addr_o,
  output logic                               in_bounds_o
);

  coag_pkg::cfg_t cfg;

  coag_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  coag_pipe #(
    .NumDims (NumDims)
  ) u_pipe (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .batch_index_i (batch_index_i),
    .in_channel_i  (in_channel_i),
    .out_channel_i (out_channel_i),
    .out_row_i     (out_row_i),
    .out_col_i     (out_col_i),
    .ker_row_i     (ker_row_i),
    .ker_col_i     (ker_col_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .output_addr_o (output_addr_o),
    .weight_addr_o (weight_addr_o),
    .input_addr_o  (input_addr_o),
    .in_bounds_o   (in_bounds_o)
  );

endmodule

`default_nettype wire
